// ----- rtl/uds_pkg.sv -----
package uds_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned MaxRes = 3;
	localparam int unsigned ResCntW = 2;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [ResCntW-1:0] rcnt_t;

	// pending sequence depth
	localparam rcnt_t PendNone = 2'd0;
	localparam rcnt_t PendLead = 2'd1;
	localparam rcnt_t PendCont = 2'd2;

	localparam byte_t ContMask = 8'hC0;
	localparam byte_t ContTag  = 8'h80;

	function automatic logic is_cont(input byte_t b);
		return (b & ContMask) == ContTag;
	endfunction

	function automatic logic is_lead2(input byte_t b);
		return b[7:5] == 3'b110;
	endfunction

	function automatic logic is_lead3(input byte_t b);
		return b[7:4] == 4'b1110;
	endfunction

	// two-byte code points, 11 bits; zero means no mapping
	function automatic byte_t map_two(input logic [10:0] cp);
		byte_t r;
		r = 8'h00;
		if (cp >= 11'h0C0 && cp <= 11'h0C6) r = "A";
		else if (cp == 11'h0C7) r = "C";
		else if (cp >= 11'h0C8 && cp <= 11'h0CB) r = "E";
		else if (cp >= 11'h0CC && cp <= 11'h0CF) r = "I";
		else if (cp == 11'h0D0) r = "D";
		else if (cp == 11'h0D1) r = "N";
		else if (cp >= 11'h0D2 && cp <= 11'h0D6) r = "O";
		else if (cp == 11'h0D8) r = "O";
		else if (cp >= 11'h0D9 && cp <= 11'h0DC) r = "U";
		else if (cp == 11'h0DD) r = "Y";
		else if (cp == 11'h0DE) r = "P";
		else if (cp == 11'h110 || cp == 11'h111) r = "d";
		else if (cp == 11'h128 || cp == 11'h129) r = "I";
		else if (cp == 11'h168 || cp == 11'h169) r = "U";
		else if (cp == 11'h1A0 || cp == 11'h1A1) r = "O";
		else if (cp == 11'h1AF || cp == 11'h1B0) r = "U";
		else if (cp >= 11'h0E0 && cp <= 11'h0E6) r = "a";
		else if (cp == 11'h0E7) r = "c";
		else if (cp >= 11'h0E8 && cp <= 11'h0EB) r = "e";
		else if (cp >= 11'h0EC && cp <= 11'h0EF) r = "i";
		else if (cp == 11'h0F0) r = "d";
		else if (cp == 11'h0F1) r = "n";
		else if (cp >= 11'h0F2 && cp <= 11'h0F6) r = "o";
		else if (cp == 11'h0F8) r = "o";
		else if (cp >= 11'h0F9 && cp <= 11'h0FC) r = "u";
		else if (cp == 11'h0FD) r = "y";
		else if (cp == 11'h0FE) r = "p";
		else if (cp == 11'h0FF) r = "y";
		return r;
	endfunction

	// vietnamese extended block, 16-bit code points
	function automatic byte_t map_three(input logic [15:0] cp);
		byte_t r;
		r = 8'h00;
		if (cp >= 16'h1EA0 && cp <= 16'h1EB7) r = "a";
		else if (cp >= 16'h1EB8 && cp <= 16'h1EC7) r = "e";
		else if (cp >= 16'h1EC8 && cp <= 16'h1ECB) r = "i";
		else if (cp >= 16'h1ECC && cp <= 16'h1EE3) r = "o";
		else if (cp >= 16'h1EE4 && cp <= 16'h1EF1) r = "u";
		else if (cp >= 16'h1EF2 && cp <= 16'h1EF9) r = "y";
		return r;
	endfunction

endpackage

// ----- rtl/utf8_diacritic_stripper_unit.sv -----
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// in       | in_valid in_ready in_byte in_last | into unit
// out      | out_valid out_ready out_byte out_last | out of unit
//
// an item is registered in the input stage, decoded against the pending
// sequence state in one pass and loaded into a three-entry result buffer.
// an item that yields at most one result lets the next item follow it while
// out_ready is high; after an item that yields more, the next item waits in
// the input stage while the result buffer drains one result per cycle with
// out_ready high. reset clears the pending state and both valid flags;
// out_ready low stalls the buffer and, once the input stage is full, the input.
module utf8_diacritic_stripper_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	// input stage
	logic                 v_s1;
	uds_pkg::byte_t       byte_s1;
	logic                 last_s1;

	// pending sequence state
	uds_pkg::byte_t       lead_q;
	uds_pkg::byte_t       cont_q;
	uds_pkg::rcnt_t       pcnt_q;

	// result buffer, entry 0 is the head
	uds_pkg::byte_t       res_byte_q [uds_pkg::MaxRes];
	logic [uds_pkg::MaxRes-1:0] res_last_q;
	uds_pkg::rcnt_t       res_cnt_q;

	// decode results
	uds_pkg::byte_t       e_byte [uds_pkg::MaxRes];
	logic [uds_pkg::MaxRes-1:0] e_last;
	uds_pkg::rcnt_t       e_n;
	uds_pkg::byte_t       nx_lead;
	uds_pkg::byte_t       nx_cont;
	uds_pkg::rcnt_t       nx_pcnt;

	logic pop;
	logic can_load;
	logic advance;

	assign out_valid = (res_cnt_q != '0);
	assign out_byte  = res_byte_q[0];
	assign out_last  = res_last_q[0];
	assign pop       = out_valid && out_ready;
	// buffer takes a new batch once it is empty or its last entry leaves now
	assign can_load  = (res_cnt_q == '0) || (res_cnt_q == 2'd1 && pop);
	assign advance   = v_s1 && can_load;
	assign in_ready  = !v_s1 || advance;

	// one-pass decode of the registered byte against the pending sequence
	always_comb begin
		uds_pkg::byte_t r;
		logic           done;
		e_byte  = '{default: '0};
		e_last  = '0;
		e_n     = '0;
		nx_lead = lead_q;
		nx_cont = cont_q;
		nx_pcnt = pcnt_q;
		done    = 1'b0;
		r       = '0;

		case (pcnt_q)
			uds_pkg::PendLead: begin
				if (uds_pkg::is_cont(byte_s1)) begin
					if (uds_pkg::is_lead2(lead_q)) begin
						r = uds_pkg::map_two({lead_q[4:0], byte_s1[5:0]});
						e_byte[e_n] = (r != '0) ? r : lead_q;
						e_n = e_n + 2'd1;
						nx_pcnt = uds_pkg::PendNone;
					end else begin
						// three-byte lead, hold first continuation
						nx_cont = byte_s1;
						nx_pcnt = uds_pkg::PendCont;
					end
					done = 1'b1;
				end else begin
					// broken sequence: lead goes out as is
					e_byte[e_n] = lead_q;
					e_n = e_n + 2'd1;
					nx_pcnt = uds_pkg::PendNone;
				end
			end
			uds_pkg::PendCont: begin
				if (uds_pkg::is_cont(byte_s1)) begin
					r = uds_pkg::map_three({lead_q[3:0], cont_q[5:0], byte_s1[5:0]});
					e_byte[e_n] = (r != '0) ? r : lead_q;
					e_n = e_n + 2'd1;
					nx_pcnt = uds_pkg::PendNone;
					done = 1'b1;
				end else begin
					e_byte[e_n] = lead_q;
					e_n = e_n + 2'd1;
					e_byte[e_n] = cont_q;
					e_n = e_n + 2'd1;
					nx_pcnt = uds_pkg::PendNone;
				end
			end
			default: begin
				nx_pcnt = uds_pkg::PendNone;
			end
		endcase

		// current byte handled afresh
		if (!done) begin
			if (!byte_s1[7]) begin
				e_byte[e_n] = byte_s1;
				e_n = e_n + 2'd1;
			end else if (uds_pkg::is_lead2(byte_s1) || uds_pkg::is_lead3(byte_s1)) begin
				nx_lead = byte_s1;
				nx_cont = '0;
				nx_pcnt = uds_pkg::PendLead;
			end else begin
				e_byte[e_n] = byte_s1;
				e_n = e_n + 2'd1;
			end
		end

		// end of text flushes whatever is pending
		if (last_s1) begin
			if (nx_pcnt == uds_pkg::PendLead || nx_pcnt == uds_pkg::PendCont) begin
				e_byte[e_n] = nx_lead;
				e_n = e_n + 2'd1;
			end
			if (nx_pcnt == uds_pkg::PendCont) begin
				e_byte[e_n] = nx_cont;
				e_n = e_n + 2'd1;
			end
			nx_pcnt = uds_pkg::PendNone;
			if (e_n != '0) begin
				e_last[e_n - 2'd1] = 1'b1;
			end
		end

		if (nx_pcnt == uds_pkg::PendNone) begin
			nx_lead = '0;
			nx_cont = '0;
		end
	end

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// pending state moves once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			cont_q <= '0;
			pcnt_q <= uds_pkg::PendNone;
		end else if (advance) begin
			lead_q <= nx_lead;
			cont_q <= nx_cont;
			pcnt_q <= nx_pcnt;
		end
	end

	// result buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else if (advance) begin
			res_cnt_q <= e_n;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	// result buffer payload: load a batch or shift toward the head
	always_ff @(posedge clk) begin
		if (advance) begin
			res_byte_q <= e_byte;
			res_last_q <= e_last;
		end else if (pop) begin
			res_byte_q[0] <= res_byte_q[1];
			res_byte_q[1] <= res_byte_q[2];
			res_last_q[0] <= res_last_q[1];
			res_last_q[1] <= res_last_q[2];
		end
	end

endmodule
